/* design/iddt_pkg.sv */
// ----------------------------------------------------------------------------
// iddt_pkg
// Shared types and constants for the indentation token scanner: token codes,
// byte codes, the per-input token limit and the controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package iddt_pkg;

   // token codes on the result channel
   localparam logic [1:0] TOK_INDENT  = 2'd0;
   localparam logic [1:0] TOK_DEDENT  = 2'd1;
   localparam logic [1:0] TOK_NEWLINE = 2'd2;

   // request kinds
   localparam logic REQ_CHAR = 1'b0;
   localparam logic REQ_EOI  = 1'b1;

   // bytes that matter to the line-start scan
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;

   // at most this many tokens for one input word
   localparam int MAX_RESULTS  = 32;
   localparam int RESULT_CNT_W = $clog2(MAX_RESULTS + 1);

   // controller to datapath
   typedef struct packed {
      logic       accept;     // input word taken this cycle
      logic       push;       // open a deeper level
      logic       pop;        // close the top level
      logic       clr_n;      // restart the token count of this input
      logic       emit;       // write a token into the result queue
      logic [1:0] emit_kind;
      logic       emit_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_eoi;     // word on the input is an end-of-input mark
      logic decide;     // word ends a line-start scan
      logic go_indent;
      logic go_dedent;
      logic go_newline;
      logic ded_more;   // another level above the line's indent may be closed
      logic eoi_pop;    // end of input may close one more level
      logic eoi_more;   // and one after that
      logic eoi_nl;     // end of input ends with NEWLINE
   } status_type;

endpackage

`default_nettype wire

/* design/iddt_if.sv */
// ----------------------------------------------------------------------------
// iddt interfaces
// Valid/ready channels: the request channel carrying bytes and token flags,
// and the response channel carrying tokens.
// ----------------------------------------------------------------------------
`default_nettype none

interface iddt_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] char_byte;
   logic       allow_indent;
   logic       allow_dedent;
   logic       allow_newline;

   modport source (output valid, req_type, char_byte, allow_indent, allow_dedent,
                   allow_newline, input ready);
   modport sink   (input valid, req_type, char_byte, allow_indent, allow_dedent,
                   allow_newline, output ready);
endinterface

interface iddt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] token_kind;
   logic       token_last;

   modport source (output valid, token_kind, token_last, input ready);
   modport sink   (input valid, token_kind, token_last, output ready);
endinterface

`default_nettype wire

/* design/iddt_outq.sv */
// ----------------------------------------------------------------------------
// iddt_outq
// Two-entry token queue in front of the response channel, so the scanner can
// keep taking bytes while a token waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module iddt_outq (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire logic [1:0] push_kind,
   input  wire logic       push_last,
   output      logic       full,
   iddt_rsp_if.source      rsp_chan
);

   logic       head_valid_ff, head_valid_in;
   logic       tail_valid_ff, tail_valid_in;
   logic [2:0] head_ff, head_in;
   logic [2:0] tail_ff, tail_in;
   logic       deq;

   always_comb begin
      deq           = head_valid_ff & rsp_chan.ready;
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      if (deq) begin
         head_valid_in = tail_valid_ff | push;
         tail_valid_in = tail_valid_ff & push;
         head_in       = tail_valid_ff ? tail_ff : {push_kind, push_last};
         if (tail_valid_ff && push) begin
            tail_in = {push_kind, push_last};
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = {push_kind, push_last};
         end else begin
            tail_valid_in = 1'b1;
            tail_in       = {push_kind, push_last};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign full                = tail_valid_ff;
   assign rsp_chan.valid      = head_valid_ff;
   assign rsp_chan.token_kind = head_ff[2:1];
   assign rsp_chan.token_last = head_ff[0];

   // a word is never written into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !tail_valid_ff)
      else $error("token written into full queue");

   // the tail slot is only ever filled behind a waiting head
   assert property (@(posedge clock) disable iff (reset) tail_valid_ff |-> head_valid_ff)
      else $error("queue tail valid without head");

   // a waiting token not taken stays at the head
   assert property (@(posedge clock) disable iff (reset)
      head_valid_ff && !rsp_chan.ready |=> head_valid_ff && $stable(head_ff))
      else $error("waiting token lost");

endmodule

`default_nettype wire

/* design/iddt_dpath.sv */
// ----------------------------------------------------------------------------
// iddt_dpath
// Line-start scan registers, the indentation level stack and its top-of-stack
// register, and the token count of the current input.
// ----------------------------------------------------------------------------
`default_nettype none

module iddt_dpath #(
   parameter int MAX_LEVELS  = 32,
   parameter int LEVEL_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire iddt_pkg::cmd_type     cmd,
   input  wire logic                  req_type,
   input  wire logic [7:0]            char_byte,
   input  wire logic                  allow_indent,
   input  wire logic                  allow_dedent,
   input  wire logic                  allow_newline,
   output      iddt_pkg::status_type  status
);

   localparam int CNT_W = $clog2(MAX_LEVELS + 1);
   localparam int IDX_W = $clog2(MAX_LEVELS);
   localparam int RES_W = iddt_pkg::RESULT_CNT_W;

   typedef enum logic [1:0] {
      PH_BETWEEN,
      PH_SPACES,
      PH_TABS
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic                   cr_ff, cr_in;
   logic [LEVEL_WIDTH-1:0] space_ff, space_in;
   logic [2:0]             allow_ff, allow_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [RES_W-1:0]       n_ff, n_in;
   logic [LEVEL_WIDTH-1:0] top_ff;

   logic [LEVEL_WIDTH-1:0] stack_mem [MAX_LEVELS];

   logic [2:0]       flags;
   logic             is_brk, is_cr, is_lf, is_tab, is_sp;
   logic             room;
   logic             deeper, shallower;
   logic [IDX_W-1:0] rd_idx;

   always_comb begin
      flags  = {allow_newline, allow_dedent, allow_indent};
      is_lf  = (char_byte == iddt_pkg::CH_LF);
      is_cr  = (char_byte == iddt_pkg::CH_CR);
      is_brk = is_lf | is_cr;
      is_tab = (char_byte == iddt_pkg::CH_TAB);
      is_sp  = (char_byte == iddt_pkg::CH_SP);
      room   = (count_ff < CNT_W'(MAX_LEVELS));
      deeper    = (space_ff > top_ff);
      shallower = (space_ff < top_ff);
      rd_idx = IDX_W'(count_ff - CNT_W'(2));

      status.is_eoi     = (req_type == iddt_pkg::REQ_EOI);
      status.decide     = (req_type == iddt_pkg::REQ_CHAR) && (phase_ff != PH_BETWEEN)
                          && !(cr_ff && is_lf) && !is_brk && !is_tab
                          && !(is_sp && phase_ff == PH_SPACES);
      status.go_indent  = deeper & allow_ff[0];
      status.go_dedent  = !status.go_indent & shallower & allow_ff[1];
      status.go_newline = !status.go_indent & !status.go_dedent & allow_ff[2];
      status.ded_more   = (count_ff > CNT_W'(1)) && (n_ff < RES_W'(iddt_pkg::MAX_RESULTS))
                          && (top_ff > space_ff);
      status.eoi_pop    = allow_ff[1] && (count_ff > CNT_W'(1))
                          && (n_ff < RES_W'(iddt_pkg::MAX_RESULTS - 1));
      status.eoi_more   = (count_ff > CNT_W'(2))
                          && (n_ff < RES_W'(iddt_pkg::MAX_RESULTS - 2));
      status.eoi_nl     = allow_ff[2];
   end

   // line-start scan
   always_comb begin
      phase_in = phase_ff;
      cr_in    = cr_ff;
      space_in = space_ff;
      allow_in = allow_ff;
      if (cmd.accept) begin
         if (status.is_eoi) begin
            // during a scan the latched flags hold, otherwise the word's own
            allow_in = (phase_ff != PH_BETWEEN) ? allow_ff : flags;
            phase_in = PH_BETWEEN;
            cr_in    = 1'b0;
            space_in = '0;
         end else if (phase_ff == PH_BETWEEN) begin
            if (is_brk && flags != 3'b000) begin
               allow_in = flags;
               phase_in = PH_SPACES;
               space_in = '0;
               cr_in    = is_cr;
            end
         end else if (cr_ff && is_lf) begin
            cr_in = 1'b0;
         end else begin
            cr_in = 1'b0;
            if (is_brk) begin
               // blank line, start over
               phase_in = PH_SPACES;
               space_in = '0;
               cr_in    = is_cr;
            end else if (is_tab) begin
               phase_in = PH_TABS;
            end else if (is_sp && phase_ff == PH_SPACES) begin
               if (space_ff != '1) begin
                  space_in = space_ff + LEVEL_WIDTH'(1);
               end
            end else begin
               // space_ff is kept for the dedent run that may follow
               phase_in = PH_BETWEEN;
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push && room) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      n_in = (cmd.clr_n ? RES_W'(0) : n_ff) + RES_W'(cmd.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BETWEEN;
         cr_ff    <= 1'b0;
         space_ff <= '0;
         allow_ff <= 3'b000;
         count_ff <= CNT_W'(1);
         n_ff     <= '0;
         top_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cr_ff    <= cr_in;
         space_ff <= space_in;
         allow_ff <= allow_in;
         count_ff <= count_in;
         n_ff     <= n_in;
         if (cmd.push && room) begin
            top_ff <= space_ff;
         end else if (cmd.pop) begin
            // the base level is never stored, it is always zero
            top_ff <= (count_ff == CNT_W'(2)) ? LEVEL_WIDTH'(0) : stack_mem[rd_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push && room) begin
         stack_mem[count_ff[IDX_W-1:0]] <= space_ff;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff != CNT_W'(0) && count_ff <= CNT_W'(MAX_LEVELS))
      else $error("level count out of range");

   assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'(1) |-> top_ff == LEVEL_WIDTH'(0))
      else $error("base level not zero");

   assert property (@(posedge clock) disable iff (reset) cmd.pop |-> count_ff > CNT_W'(1))
      else $error("pop of base level");

   assert property (@(posedge clock) disable iff (reset) !(cmd.push && cmd.pop))
      else $error("push and pop together");

endmodule

`default_nettype wire

/* design/iddt_ctrl.sv */
// ----------------------------------------------------------------------------
// iddt_ctrl
// Sequencer: takes input words, starts pushes and pop runs, and writes the
// tokens into the result queue with the last-token mark.
// ----------------------------------------------------------------------------
`default_nettype none

module iddt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic                 q_full,
   input  wire iddt_pkg::status_type status,
   output      iddt_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEDENT,
      ST_EOI
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !q_full;
            if (req_valid && !q_full) begin
               cmd.accept = 1'b1;
               if (status.is_eoi) begin
                  cmd.clr_n = 1'b1;
                  state_in  = ST_EOI;
               end else if (status.decide) begin
                  if (status.go_indent) begin
                     cmd.push      = 1'b1;
                     cmd.emit      = 1'b1;
                     cmd.emit_kind = iddt_pkg::TOK_INDENT;
                     cmd.emit_last = 1'b1;
                  end else if (status.go_dedent) begin
                     // first level closes now, its token is written from ST_DEDENT
                     cmd.pop   = 1'b1;
                     cmd.clr_n = 1'b1;
                     state_in  = ST_DEDENT;
                  end else if (status.go_newline) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_kind = iddt_pkg::TOK_NEWLINE;
                     cmd.emit_last = 1'b1;
                  end
               end
            end
         end
         ST_DEDENT: begin
            if (!q_full) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = iddt_pkg::TOK_DEDENT;
               cmd.emit_last = !status.ded_more;
               if (status.ded_more) begin
                  cmd.pop = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EOI: begin
            if (!q_full) begin
               if (status.eoi_pop) begin
                  cmd.pop       = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = iddt_pkg::TOK_DEDENT;
                  cmd.emit_last = !(status.eoi_more || status.eoi_nl);
               end else begin
                  if (status.eoi_nl) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_kind = iddt_pkg::TOK_NEWLINE;
                     cmd.emit_last = 1'b1;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* design/indent_dedent_tokenizer_top.sv */
// ----------------------------------------------------------------------------
// indent_dedent_tokenizer_top
// Offside-rule indentation scanner: turns a byte stream and the parser's
// allowed-token flags into INDENT, DEDENT and NEWLINE tokens.
//
//   channel    dir  role                                 accepted when
//   req_chan   in   byte or end-of-input, token flags    valid && ready
//   rsp_chan   out  token kind, last-of-word mark        valid && ready
//
// One input word per cycle while no pop run is active and the two-entry
// token queue has a free slot.
// A dedent run first pops one level, reading the level stack, then gives
// one DEDENT per cycle; an end-of-input run gives one token per cycle.
// Reset is synchronous; the level stack needs no clearing.
// A full token queue stalls both input and the pop sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module indent_dedent_tokenizer_top #(
   parameter int MAX_LEVELS  = 32,
   parameter int LEVEL_WIDTH = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   iddt_req_if.sink    req_chan,
   iddt_rsp_if.source  rsp_chan
);

   iddt_pkg::cmd_type    cmd;
   iddt_pkg::status_type status;
   logic                 q_full;

   iddt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .q_full    (q_full),
      .status    (status),
      .cmd       (cmd)
   );

   iddt_dpath #(
      .MAX_LEVELS  (MAX_LEVELS),
      .LEVEL_WIDTH (LEVEL_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_type      (req_chan.req_type),
      .char_byte     (req_chan.char_byte),
      .allow_indent  (req_chan.allow_indent),
      .allow_dedent  (req_chan.allow_dedent),
      .allow_newline (req_chan.allow_newline),
      .status        (status)
   );

   iddt_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd.emit),
      .push_kind (cmd.emit_kind),
      .push_last (cmd.emit_last),
      .full      (q_full),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

/* test/indent_dedent_tokenizer_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indent_dedent_tokenizer_top_tb
// Drives byte words and end-of-input marks with parser flags into the
// indentation scanner and checks every INDENT, DEDENT and NEWLINE token, with
// its last mark, against a line-scan tracker kept in the bench. Directed
// scenarios cover quiet bytes, nesting, break forms, flag fallbacks, end of
// input inside a scan and nesting under a held-off receiver; random
// indented text follows. Both channels idle in random bursts.
// ----------------------------------------------------------------------------

module indent_dedent_tokenizer_top_tb;

   localparam int MAX_LVL      = 32;
   localparam int LVL_W        = 16;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD    = 300;
   localparam int ITEM_TARGET  = 150;

   // flag bits: indent, dedent, newline
   localparam logic [2:0] FL_NONE = 3'b000;
   localparam logic [2:0] FL_IND  = 3'b001;
   localparam logic [2:0] FL_DED  = 3'b010;
   localparam logic [2:0] FL_NL   = 3'b100;
   localparam logic [2:0] FL_ALL  = 3'b111;

   typedef enum logic [1:0] {SCAN_IDLE, SCAN_SPACES, SCAN_TABS} scan_phase_type;
   typedef enum int {BRK_LF, BRK_CR, BRK_CRLF} line_break_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       last;
   } token_type;

   logic clock;
   logic reset;

   iddt_req_if req();
   iddt_rsp_if rsp();

   indent_dedent_tokenizer_top #(
      .MAX_LEVELS (MAX_LVL),
      .LEVEL_WIDTH(LVL_W)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req),
      .rsp_chan(rsp)
   );

   // line-scan tracker state
   logic [LVL_W-1:0] level_stack [MAX_LVL];
   int               level_count;
   scan_phase_type   phase;
   logic             cr_pending;
   logic [LVL_W-1:0] space_count;
   logic [2:0]       line_flags;

   token_type pending_tokens[$];

   int errors       = 0;
   int words_sent   = 0;
   int scan_words   = 0;
   int tokens_seen  = 0;
   int quiet_cycles = 0;
   int hold_request = 0;
   bit idle_on      = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void close_line();
      phase       = SCAN_IDLE;
      cr_pending  = 1'b0;
      space_count = '0;
   endfunction

   function automatic void reset_tracker();
      foreach (level_stack[i]) level_stack[i] = '0;
      level_count = 1;
      line_flags  = FL_NONE;
      close_line();
   endfunction

   function automatic void push_token(logic [1:0] kind);
      token_type t;
      t.kind = kind;
      t.last = 1'b0;
      pending_tokens.push_back(t);
   endfunction

   // advance the line scan by one accepted word and queue the tokens it gives
   function automatic void predict_tokens(logic kind, logic [7:0] b, logic [2:0] flags);
      int               n;
      bit               is_break;
      logic [2:0]       use_flags;
      logic [LVL_W-1:0] top;
      token_type        tail;
      n = 0;
      is_break = (b == iddt_pkg::CH_LF) || (b == iddt_pkg::CH_CR);
      if (kind == iddt_pkg::REQ_EOI) begin
         scan_words++;
         use_flags = (phase != SCAN_IDLE) ? line_flags : flags;
         if (use_flags[1]) begin
            while (level_count > 1 && n < iddt_pkg::MAX_RESULTS - 1) begin
               level_count--;
               push_token(iddt_pkg::TOK_DEDENT);
               n++;
            end
         end
         if (use_flags[2]) begin
            push_token(iddt_pkg::TOK_NEWLINE);
            n++;
         end
         close_line();
      end else if (phase == SCAN_IDLE) begin
         if (is_break && flags != FL_NONE) begin
            scan_words++;
            line_flags  = flags;
            phase       = SCAN_SPACES;
            space_count = '0;
            cr_pending  = (b == iddt_pkg::CH_CR);
         end
      end else begin
         scan_words++;
         if (cr_pending && b == iddt_pkg::CH_LF) begin
            cr_pending = 1'b0;
         end else begin
            cr_pending = 1'b0;
            if (is_break) begin
               phase       = SCAN_SPACES;
               space_count = '0;
               cr_pending  = (b == iddt_pkg::CH_CR);
            end else if (b == iddt_pkg::CH_TAB) begin
               phase = SCAN_TABS;
            end else if (b == iddt_pkg::CH_SP && phase == SCAN_SPACES) begin
               if (space_count != '1) space_count++;
            end else begin
               top = level_stack[level_count - 1];
               if (space_count > top && line_flags[0]) begin
                  if (level_count < MAX_LVL) begin
                     level_stack[level_count] = space_count;
                     level_count++;
                  end
                  push_token(iddt_pkg::TOK_INDENT);
                  n++;
               end else if (space_count < top && line_flags[1]) begin
                  while (level_count > 1 && n < iddt_pkg::MAX_RESULTS &&
                         level_stack[level_count - 1] > space_count) begin
                     level_count--;
                     push_token(iddt_pkg::TOK_DEDENT);
                     n++;
                  end
               end else if (line_flags[2]) begin
                  push_token(iddt_pkg::TOK_NEWLINE);
                  n++;
               end
               close_line();
            end
         end
      end
      if (n > 0) begin
         tail      = pending_tokens.pop_back();
         tail.last = 1'b1;
         pending_tokens.push_back(tail);
      end
   endfunction

   // offer one word, hold it until taken, then track it
   task automatic put_word(logic kind, logic [7:0] b, logic [2:0] flags);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.req_type      <= kind;
      req.char_byte     <= b;
      req.allow_indent  <= flags[0];
      req.allow_dedent  <= flags[1];
      req.allow_newline <= flags[2];
      do @(posedge clock); while (!req.ready);
      words_sent++;
      predict_tokens(kind, b, flags);
   endtask

   task automatic put_break(line_break_type brk, logic [2:0] flags);
      case (brk)
         BRK_LF: put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_LF, flags);
         BRK_CR: put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_CR, flags);
         default: begin
            put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_CR, flags);
            put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_LF, flags);
         end
      endcase
   endtask

   task automatic put_line(line_break_type brk, logic [2:0] flags, int spaces,
                           logic [7:0] first);
      put_break(brk, flags);
      repeat (spaces) put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_SP, flags);
      put_word(iddt_pkg::REQ_CHAR, first, flags);
   endtask

   // stop offering and wait for every queued token
   task automatic wait_drained();
      req.valid <= 1'b0;
      do @(posedge clock); while (pending_tokens.size() != 0);
   endtask

   task automatic test_quiet_bytes();
      put_word(iddt_pkg::REQ_CHAR, 8'h00, FL_ALL);
      put_word(iddt_pkg::REQ_CHAR, 8'hFF, FL_ALL);
      put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_SP, FL_ALL);
      put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_TAB, FL_ALL);
      put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_LF, FL_NONE);
      put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_CR, FL_NONE);
      put_word(iddt_pkg::REQ_EOI, 8'hFF, FL_NL);
      put_word(iddt_pkg::REQ_EOI, 8'h00, FL_NONE);
      wait_drained();
   endtask

   task automatic test_nesting();
      put_line(BRK_LF, FL_ALL, 2, "a");
      put_line(BRK_LF, FL_ALL, 4, "b");
      put_line(BRK_LF, FL_ALL, 4, "c");
      put_line(BRK_LF, FL_ALL, 1, "d");
      put_line(BRK_LF, FL_ALL, 0, "e");
      wait_drained();
   endtask

   task automatic test_line_breaks();
      put_line(BRK_CRLF, FL_ALL, 3, "f");
      put_line(BRK_CR, FL_ALL, 3, "g");
      // blank lines restart the count, CR CR LF is two breaks
      put_break(BRK_LF, FL_ALL);
      repeat (5) put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_SP, FL_ALL);
      put_break(BRK_CR, FL_ALL);
      put_break(BRK_CR, FL_ALL);
      put_line(BRK_LF, FL_ALL, 3, "h");
      // a space after tabs decides the line
      put_break(BRK_LF, FL_ALL);
      repeat (2) put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_SP, FL_ALL);
      put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_TAB, FL_ALL);
      put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_TAB, FL_ALL);
      put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_SP, FL_ALL);
      wait_drained();
   endtask

   task automatic test_fallback();
      put_line(BRK_LF, FL_NL, 2, "i");
      put_line(BRK_LF, FL_DED, 2, "j");
      put_line(BRK_LF, FL_IND, 2, "k");
      put_line(BRK_LF, FL_IND, 2, "l");
      put_line(BRK_LF, FL_IND | FL_NL, 0, "m");
      put_line(BRK_LF, FL_DED, 0, "n");
      wait_drained();
   endtask

   task automatic test_eoi_in_scan();
      put_line(BRK_LF, FL_ALL, 2, "o");
      put_line(BRK_LF, FL_ALL, 6, "p");
      put_break(BRK_LF, FL_IND | FL_NL);
      put_word(iddt_pkg::REQ_EOI, 8'h00, FL_ALL);
      put_break(BRK_LF, FL_DED | FL_NL);
      put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_SP, FL_ALL);
      put_word(iddt_pkg::REQ_EOI, 8'h00, FL_NONE);
      put_line(BRK_LF, FL_ALL, 1, "q");
      put_word(iddt_pkg::REQ_EOI, 8'h00, FL_DED);
      wait_drained();
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_pressure();
      hold_request = LONG_HOLD;
      for (int i = 1; i <= 4; i++) put_line(BRK_LF, FL_ALL, i, "r");
      put_word(iddt_pkg::REQ_EOI, 8'h00, FL_ALL);
      wait_drained();
   endtask

   task automatic put_random_line();
      logic [2:0] flags;
      logic [7:0] first;
      int         spaces;
      flags = ($urandom_range(0, 4) != 0) ? FL_ALL : 3'($urandom_range(0, 7));
      if ($urandom_range(0, 4) == 0) begin
         put_break(line_break_type'($urandom_range(0, 2)), flags);
         repeat ($urandom_range(0, 3)) begin
            put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_SP, 3'($urandom));
         end
      end
      put_break(line_break_type'($urandom_range(0, 2)), flags);
      spaces = 2 * $urandom_range(0, 8) + (($urandom_range(0, 7) == 0) ? 1 : 0);
      repeat (spaces) put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_SP, 3'($urandom));
      if ($urandom_range(0, 6) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            put_word(iddt_pkg::REQ_CHAR, iddt_pkg::CH_TAB, 3'($urandom));
         end
      end
      if ($urandom_range(0, 4) != 0) first = 8'($urandom_range(8'h21, 8'h7E));
      else first = 8'($urandom);
      put_word(iddt_pkg::REQ_CHAR, first, 3'($urandom));
      // rest of the line, mostly ignored
      repeat ($urandom_range(0, 4)) begin
         put_word(iddt_pkg::REQ_CHAR, 8'($urandom),
                  ($urandom_range(0, 3) == 0) ? 3'($urandom) : FL_NONE);
      end
      if ($urandom_range(0, 24) == 0) begin
         put_word(iddt_pkg::REQ_EOI, 8'($urandom), 3'($urandom));
      end
   endtask

   task automatic test_random_text();
      while (words_sent < ITEM_TARGET) begin
         if (words_sent >= ITEM_TARGET - 20) idle_on = 1'b0;
         put_random_line();
         if ($urandom_range(0, 19) == 0) wait_drained();
      end
   endtask

   // token sink: random stalls, long hold on request, checks each word
   initial begin : token_sink
      int        stall_left;
      int        hold_left;
      token_type want;
      stall_left = 0;
      hold_left  = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            tokens_seen++;
            if (pending_tokens.size() == 0) begin
               errors++;
               $display("%0t: unexpected token: expected none, actual kind %0d last %0d",
                        $time, rsp.token_kind, rsp.token_last);
            end else begin
               want = pending_tokens.pop_front();
               if (rsp.token_kind !== want.kind || rsp.token_last !== want.last) begin
                  errors++;
                  $display("%0t: token mismatch: expected kind %0d last %0d, actual kind %0d last %0d",
                           $time, want.kind, want.last, rsp.token_kind, rsp.token_last);
               end
            end
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no word taken on either side
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d tokens outstanding",
                  $time, quiet_cycles, pending_tokens.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset_tracker();
      reset             <= 1'b1;
      req.valid         <= 1'b0;
      req.req_type      <= iddt_pkg::REQ_CHAR;
      req.char_byte     <= 8'h00;
      req.allow_indent  <= 1'b0;
      req.allow_dedent  <= 1'b0;
      req.allow_newline <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;

      test_quiet_bytes();
      test_nesting();
      test_line_breaks();
      test_fallback();
      test_eoi_in_scan();
      test_pressure();
      test_random_text();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d words sent, %0d reached the line scan, %0d tokens checked",
               words_sent, scan_words, tokens_seen);
      $display("run: nesting, break forms, flag fallbacks, held-off receiver, random text");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
